### rtl/oss_pkg.sv
// Shared types, codes and constants of the one-wire sensor scan sequencer.
package oss_pkg;

    // Default table depth
    localparam int MAX_DEVICES_DEF = 8;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FAMILY_CODE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONVERT_WAIT_MS = 4'd1;
    localparam logic [7:0] FAMILY_CODE_RESET     = 8'd40;
    localparam logic [9:0] CONVERT_WAIT_MS_RESET = 10'd750;

    // Scan average: large differences move by a sixteenth, small ones by one
    localparam int AVG_DEADBAND = 15;
    localparam int AVG_SHIFT    = 4;

    // Bus master command codes
    typedef enum logic [2:0] {
        CMD_NONE         = 3'd0,
        CMD_SEARCH_FIRST = 3'd1,
        CMD_SEARCH_NEXT  = 3'd2,
        CMD_CONVERT      = 3'd3,
        CMD_READ         = 3'd4
    } cmd_t;

    // One input word
    typedef struct packed {
        logic        last_failed;
        logic [63:0] found_rom;
        logic        search_complete;
        logic [15:0] elapsed_ms;
        logic [7:0]  reply_low;
        logic [7:0]  reply_high;
    } sample_t;

    // One result word
    typedef struct packed {
        cmd_t        command;
        logic [63:0] target_rom;
        logic [9:0]  wait_ms;
        logic        reading_valid;
        logic        reading_failed;
        logic [2:0]  reading_device;
        logic [7:0]  reading_low;
        logic [7:0]  reading_high;
        logic [15:0] scan_avg_ms;
        logic [3:0]  devices_found;
    } result_t;

    // ROM table access strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } rom_ctl_t;

endpackage

### rtl/oss_if.sv
// Channel interfaces: input words, result words and configuration writes.
interface oss_sample_if;
    logic        valid;
    logic        ready;
    logic        last_failed;
    logic [63:0] found_rom;
    logic        search_complete;
    logic [15:0] elapsed_ms;
    logic [7:0]  reply_low;
    logic [7:0]  reply_high;

    modport source (
        output valid, last_failed, found_rom, search_complete, elapsed_ms,
               reply_low, reply_high,
        input  ready
    );
    modport sink (
        input  valid, last_failed, found_rom, search_complete, elapsed_ms,
               reply_low, reply_high,
        output ready
    );
endinterface

interface oss_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [63:0] target_rom;
    logic [9:0]  wait_ms;
    logic        reading_valid;
    logic        reading_failed;
    logic [2:0]  reading_device;
    logic [7:0]  reading_low;
    logic [7:0]  reading_high;
    logic [15:0] scan_avg_ms;
    logic [3:0]  devices_found;

    modport source (
        output valid, command, target_rom, wait_ms, reading_valid, reading_failed,
               reading_device, reading_low, reading_high, scan_avg_ms,
               devices_found,
        input  ready
    );
    modport sink (
        input  valid, command, target_rom, wait_ms, reading_valid, reading_failed,
               reading_device, reading_low, reading_high, scan_avg_ms,
               devices_found,
        output ready
    );
endinterface

interface oss_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [oss_pkg::CFG_IDX_W-1:0]  index;
    logic [oss_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/onewire_sensor_scan_sequencer.sv
// Sustained rate one word per clock: each accepted input word yields exactly one result word
// through a single output register, so the block takes a new word in every cycle while the
// result side keeps up (input ready = output register empty or being drained). The ROM table
// sits in a one-read, one-write synchronous memory; the entry the next word needs is read at
// the edge that accepts the current word, so the registered read costs nothing. The
// table needs no clearing pass after reset: only entries written by the last search are read.
module onewire_sensor_scan_sequencer #(
    parameter int MAX_DEVICES = oss_pkg::MAX_DEVICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    oss_sample_if.sink          sample,
    oss_result_if.source        result,
    oss_cfg_if.sink             cfg
);

    localparam int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

    logic [7:0]        family_code_reg;
    logic [9:0]        convert_wait_ms_reg;
    logic              out_valid_reg;
    oss_pkg::result_t  out_data_reg;
    oss_pkg::sample_t  smp;
    oss_pkg::result_t  res;
    oss_pkg::rom_ctl_t rom_ctl;
    logic [AW-1:0]     rom_wr_addr;
    logic [AW-1:0]     rom_rd_addr;
    logic [63:0]       rom_rd_data;
    logic              accept;

    // Gather the input word
    assign smp.last_failed     = sample.last_failed;
    assign smp.found_rom       = sample.found_rom;
    assign smp.search_complete = sample.search_complete;
    assign smp.elapsed_ms      = sample.elapsed_ms;
    assign smp.reply_low       = sample.reply_low;
    assign smp.reply_high      = sample.reply_high;

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_code_reg     <= oss_pkg::FAMILY_CODE_RESET;
            convert_wait_ms_reg <= oss_pkg::CONVERT_WAIT_MS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                oss_pkg::REG_FAMILY_CODE:     family_code_reg     <= cfg.data[7:0];
                oss_pkg::REG_CONVERT_WAIT_MS: convert_wait_ms_reg <= cfg.data[9:0];
                default:                      ;
            endcase
        end
    end

    oss_seq #(
        .MAX_DEVICES (MAX_DEVICES),
        .AW          (AW)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .smp             (smp),
        .family_code     (family_code_reg),
        .convert_wait_ms (convert_wait_ms_reg),
        .rom_rd_data     (rom_rd_data),
        .rom_ctl         (rom_ctl),
        .rom_wr_addr     (rom_wr_addr),
        .rom_rd_addr     (rom_rd_addr),
        .res             (res)
    );

    oss_rom_mem #(
        .DEPTH (MAX_DEVICES),
        .AW    (AW)
    ) u_rom_mem (
        .clk     (clk),
        .ctl     (rom_ctl),
        .wr_addr (rom_wr_addr),
        .wr_data (smp.found_rom),
        .rd_addr (rom_rd_addr),
        .rd_data (rom_rd_data)
    );

    // Output register: load on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.command        = out_data_reg.command;
    assign result.target_rom     = out_data_reg.target_rom;
    assign result.wait_ms        = out_data_reg.wait_ms;
    assign result.reading_valid  = out_data_reg.reading_valid;
    assign result.reading_failed = out_data_reg.reading_failed;
    assign result.reading_device = out_data_reg.reading_device;
    assign result.reading_low    = out_data_reg.reading_low;
    assign result.reading_high   = out_data_reg.reading_high;
    assign result.scan_avg_ms    = out_data_reg.scan_avg_ms;
    assign result.devices_found  = out_data_reg.devices_found;

endmodule

### rtl/oss_rom_mem.sv
// ROM code table: one write port, one registered read port.
module oss_rom_mem #(
    parameter int DEPTH = oss_pkg::MAX_DEVICES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  oss_pkg::rom_ctl_t ctl,
    input  logic [AW-1:0]     wr_addr,
    input  logic [63:0]       wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [63:0]       rd_data
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    // Write the found code
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry ahead of its use
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/oss_seq.sv
// Phase sequencer: search, convert and read walk, scan average, table addressing.
module oss_seq #(
    parameter int MAX_DEVICES = oss_pkg::MAX_DEVICES_DEF,
    parameter int AW          = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  oss_pkg::sample_t  smp,
    input  logic [7:0]        family_code,
    input  logic [9:0]        convert_wait_ms,
    input  logic [63:0]       rom_rd_data,
    output oss_pkg::rom_ctl_t rom_ctl,
    output logic [AW-1:0]     rom_wr_addr,
    output logic [AW-1:0]     rom_rd_addr,
    output oss_pkg::result_t  res
);

    localparam int IW = $clog2(MAX_DEVICES + 1);
    localparam logic [IW-1:0] MAX_IDX = IW'(MAX_DEVICES);
    localparam logic signed [16:0] AVG_DEADBAND_S = 17'(oss_pkg::AVG_DEADBAND);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LIST_FIRST,
        PH_LIST_NEXT,
        PH_LIST_CHECK,
        PH_CONVERT,
        PH_CONVERT_CHECK,
        PH_ENUM_START,
        PH_ENUM_FIRST,
        PH_ENUM,
        PH_READ,
        PH_EXTRACT
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [IW-1:0] device_index_reg, device_index_next;
    logic [IW-1:0] device_total_reg, device_total_next;
    logic [15:0]   scan_average_reg, scan_average_next;

    logic signed [16:0] avg_diff;
    logic signed [16:0] avg_step;
    logic signed [16:0] avg_sum;
    logic [IW-1:0]      idx_inc;
    logic [IW-1:0]      fetch_addr;
    logic               rom_wr;

    // Scan average step: a sixteenth (floored) outside the dead band, else one
    always_comb
    begin
        avg_diff = $signed({1'b0, smp.elapsed_ms}) - $signed({1'b0, scan_average_reg});
        if (avg_diff > AVG_DEADBAND_S || avg_diff < -AVG_DEADBAND_S)
        begin
            avg_step = avg_diff >>> oss_pkg::AVG_SHIFT;
        end
        else if (avg_diff > 17'sd0)
        begin
            avg_step = 17'sd1;
        end
        else if (avg_diff < 17'sd0)
        begin
            avg_step = -17'sd1;
        end
        else
        begin
            avg_step = 17'sd0;
        end
        avg_sum = $signed({1'b0, scan_average_reg}) + avg_step;
    end

    // Saturating index increment
    assign idx_inc = (device_index_reg < MAX_IDX) ? device_index_reg + 1'b1 : device_index_reg;

    // Next phase and the result word for this item
    always_comb
    begin
        phase_next        = phase_reg;
        device_index_next = device_index_reg;
        device_total_next = device_total_reg;
        scan_average_next = scan_average_reg;
        rom_wr            = 1'b0;
        res               = '0;
        res.command       = oss_pkg::CMD_NONE;

        unique case (phase_reg)
            PH_IDLE:
            begin
                scan_average_next = avg_sum[15:0];
                phase_next        = PH_LIST_FIRST;
            end
            PH_LIST_FIRST:
            begin
                device_index_next = '0;
                res.command       = oss_pkg::CMD_SEARCH_FIRST;
                phase_next        = PH_LIST_CHECK;
            end
            PH_LIST_CHECK:
            begin
                phase_next = smp.last_failed ? PH_IDLE : PH_LIST_NEXT;
            end
            PH_LIST_NEXT:
            begin
                rom_wr            = (device_index_reg < MAX_IDX);
                device_index_next = idx_inc;
                if (smp.search_complete || idx_inc >= MAX_IDX)
                begin
                    device_total_next = idx_inc;
                    phase_next        = PH_CONVERT;
                end
                else
                begin
                    res.command = oss_pkg::CMD_SEARCH_NEXT;
                    phase_next  = PH_LIST_CHECK;
                end
            end
            PH_CONVERT:
            begin
                res.command = oss_pkg::CMD_CONVERT;
                res.wait_ms = convert_wait_ms;
                phase_next  = PH_CONVERT_CHECK;
            end
            PH_CONVERT_CHECK:
            begin
                phase_next = smp.last_failed ? PH_IDLE : PH_ENUM_START;
            end
            PH_ENUM_START:
            begin
                device_index_next = '0;
                phase_next        = PH_ENUM_FIRST;
            end
            PH_ENUM_FIRST, PH_ENUM:
            begin
                // The prefetched entry is the one now under test
                if (phase_reg == PH_ENUM)
                begin
                    device_index_next = idx_inc;
                end
                if (device_index_next >= device_total_reg || device_index_next >= MAX_IDX)
                begin
                    phase_next = PH_IDLE;
                end
                else if (rom_rd_data[7:0] == family_code)
                begin
                    phase_next = PH_READ;
                end
                else
                begin
                    phase_next = PH_ENUM;
                end
            end
            PH_READ:
            begin
                res.command    = oss_pkg::CMD_READ;
                res.target_rom = rom_rd_data;
                phase_next     = PH_EXTRACT;
            end
            PH_EXTRACT:
            begin
                res.reading_valid  = 1'b1;
                res.reading_failed = smp.last_failed;
                res.reading_device = 3'(device_index_reg);
                res.reading_low    = smp.reply_low;
                res.reading_high   = smp.reply_high;
                phase_next         = PH_ENUM;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        res.scan_avg_ms   = scan_average_next;
        res.devices_found = 4'(device_total_next);
    end

    // Prefetch the entry that the next item tests or sends
    always_comb
    begin
        if (phase_next == PH_ENUM && device_index_next < MAX_IDX)
        begin
            fetch_addr = device_index_next + 1'b1;
        end
        else
        begin
            fetch_addr = device_index_next;
        end
    end

    assign rom_ctl.wr_en = accept && rom_wr;
    assign rom_ctl.rd_en = accept && (fetch_addr < MAX_IDX);
    assign rom_wr_addr   = device_index_reg[AW-1:0];
    assign rom_rd_addr   = fetch_addr[AW-1:0];

    // Hold state; advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            device_index_reg <= '0;
            device_total_reg <= '0;
            scan_average_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            device_index_reg <= device_index_next;
            device_total_reg <= device_total_next;
            scan_average_reg <= scan_average_next;
        end
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        device_total_reg <= MAX_IDX)
        else $error("device total beyond table depth");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        device_index_reg <= MAX_IDX)
        else $error("device index beyond table depth");

    a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && phase_reg == PH_IDLE) |=> $stable(scan_average_reg))
        else $error("scan average moved outside the idle phase");

    a_read_extract: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_READ) |=> phase_reg == PH_EXTRACT)
        else $error("read command not followed by extraction");

endmodule
